[sv/tclip_pkg.sv]
// Shared types, constants and arithmetic helpers for the toroidal clipmap
// origin update block. No dependencies.
package tclip_pkg;

    localparam int ORIGIN_W = 10;
    localparam int MOVE_W   = 12;
    localparam int LANES    = 4;

    localparam logic [ORIGIN_W-1:0] GRID_RESET = 10'd255;
    localparam logic [ORIGIN_W-1:0] GRID_MIN   = 10'd3;

    localparam logic [1:0] LANE_CX = 2'd0;
    localparam logic [1:0] LANE_CY = 2'd1;
    localparam logic [1:0] LANE_HX = 2'd2;
    localparam logic [1:0] LANE_HY = 2'd3;

    typedef logic [ORIGIN_W-1:0] coord_t;
    typedef logic signed [MOVE_W-1:0] move_t;

    typedef struct packed {
        logic   is_height_grid;
        logic   full_reload;
        coord_t origin_x;
        coord_t origin_y;
        coord_t row_start_x;
        coord_t row_start_y;
        coord_t col_start_x;
        coord_t col_start_y;
        logic   row_strip_valid;
        logic   col_strip_valid;
    } res_t;

    // One step of a restoring remainder: shift in one bit, subtract if it fits.
    function automatic coord_t red_step(input coord_t rem, input logic b, input coord_t m);
        logic [ORIGIN_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[ORIGIN_W-1:0];
    endfunction

    // Wrap of an origin by a move whose magnitude is at most the modulus.
    // The reduced copy of the origin keeps the sum below twice the modulus.
    function automatic coord_t wrap_red(input coord_t raw, input coord_t red,
                                        input move_t d, input coord_t m);
        logic [MOVE_W-1:0] step;
        logic [MOVE_W-1:0] s;
        logic [MOVE_W-1:0] m_w;
        m_w  = {{(MOVE_W-ORIGIN_W){1'b0}}, m};
        step = (d < 0) ? (MOVE_W'(unsigned'(d)) + m_w) : MOVE_W'(unsigned'(d));
        s    = {{(MOVE_W-ORIGIN_W){1'b0}}, red} + step;
        if (s >= m_w)
        begin
            s = s - m_w;
        end
        if (d == '0)
        begin
            return raw;
        end
        return s[ORIGIN_W-1:0];
    endfunction

    function automatic res_t make_res(input logic height, input logic reload,
                                      input coord_t ox_raw, input coord_t oy_raw,
                                      input coord_t wx, input coord_t wy,
                                      input coord_t new_ox, input coord_t new_oy,
                                      input move_t dx, input move_t dy);
        res_t r;
        logic rv;
        logic cv;
        rv = !reload && (dy != '0);
        cv = !reload && (dx != '0);
        r.is_height_grid  = height;
        r.full_reload     = reload;
        r.origin_x        = new_ox;
        r.origin_y        = new_oy;
        r.row_start_x     = rv ? wx : '0;
        r.row_start_y     = rv ? ((dy > 0) ? wy : oy_raw) : '0;
        r.col_start_x     = cv ? ((dx > 0) ? ox_raw : wx) : '0;
        r.col_start_y     = cv ? ((dy < 0) ? wy : oy_raw) : '0;
        r.row_strip_valid = rv;
        r.col_strip_valid = cv;
        return r;
    endfunction

endpackage

[sv/toroidal_clipmap_origin_update.sv]
// Toroidal clipmap origin update: origins of the colour and height grids.
// Depends on tclip_pkg for types, lane codes and the wrap arithmetic.
//
// Channel  Direction  Handshake                  Payload
// in       request    in_valid / in_ready        move_x, move_y
// out      result     out_valid / out_ready      colour result, then height result
// cfg      write      cfg_wr_en                  cfg_wr_data (grid_size)
//
// Each request yields two results, which leave one after the other through the
// single result port while out_ready is high.
// A request goes from the input register to the two-entry result buffer once
// the buffer is empty or its last result is being taken, and no reduction runs.
// After a grid_size write the stored origins are reduced by the new moduli in
// a bit-serial pass, during which in_ready is low.
// Reset brings grid_size to 255 and marks the next request as a full reload.
module toroidal_clipmap_origin_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tclip_pkg::ORIGIN_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [tclip_pkg::MOVE_W-1:0] move_x,
    input  logic signed [tclip_pkg::MOVE_W-1:0] move_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_height_grid,
    output logic                          last,
    output logic                          full_reload,
    output logic [tclip_pkg::ORIGIN_W-1:0] origin_x,
    output logic [tclip_pkg::ORIGIN_W-1:0] origin_y,
    output logic [tclip_pkg::ORIGIN_W-1:0] row_start_x,
    output logic [tclip_pkg::ORIGIN_W-1:0] row_start_y,
    output logic [tclip_pkg::ORIGIN_W-1:0] col_start_x,
    output logic [tclip_pkg::ORIGIN_W-1:0] col_start_y,
    output logic                          row_strip_valid,
    output logic                          col_strip_valid
);

    localparam int CNT_W = $clog2(tclip_pkg::ORIGIN_W);

    tclip_pkg::coord_t grid_size_reg;
    logic              first_pass_reg, first_pass_next;
    logic              red_busy_reg, red_busy_next;
    logic [CNT_W-1:0]  red_cnt_reg, red_cnt_next;
    tclip_pkg::coord_t raw_reg [tclip_pkg::LANES];
    tclip_pkg::coord_t raw_next [tclip_pkg::LANES];
    tclip_pkg::coord_t red_reg [tclip_pkg::LANES];
    tclip_pkg::coord_t red_next [tclip_pkg::LANES];

    logic              in_full_reg, in_full_next;
    tclip_pkg::move_t  mx_reg, my_reg;
    logic              buf_full_reg, buf_full_next;
    logic              phase_reg, phase_next;
    tclip_pkg::res_t   res_buf_reg [2];
    tclip_pkg::res_t   res_c, res_h, res_out;

    tclip_pkg::coord_t n_size, m_c, m_h;
    tclip_pkg::coord_t m_lane [tclip_pkg::LANES];
    tclip_pkg::move_t  d_lane [tclip_pkg::LANES];
    tclip_pkg::coord_t w_lane [tclip_pkg::LANES];
    tclip_pkg::coord_t load_lane [tclip_pkg::LANES];
    tclip_pkg::coord_t new_lane [tclip_pkg::LANES];
    logic [tclip_pkg::MOVE_W-1:0] ax, ay, lim;
    logic              reload;
    logic              out_take, buf_free, move, in_take;

    assign n_size = (grid_size_reg < tclip_pkg::GRID_MIN) ? tclip_pkg::GRID_MIN : grid_size_reg;
    assign m_c    = n_size - tclip_pkg::ORIGIN_W'(1);
    assign m_h    = n_size;

    assign out_take = buf_full_reg && out_ready;
    assign buf_free = !buf_full_reg || (out_take && phase_reg);
    assign move     = in_full_reg && buf_free && !red_busy_reg;
    assign in_ready = (!in_full_reg || move) && !red_busy_reg;
    assign in_take  = in_valid && in_ready;

    assign ax     = (mx_reg < 0) ? unsigned'(-mx_reg) : unsigned'(mx_reg);
    assign ay     = (my_reg < 0) ? unsigned'(-my_reg) : unsigned'(my_reg);
    assign lim    = {{(tclip_pkg::MOVE_W-tclip_pkg::ORIGIN_W){1'b0}}, m_c};
    assign reload = first_pass_reg || (ax > lim) || (ay > lim);

    always_comb
    begin
        m_lane[tclip_pkg::LANE_CX]    = m_c;
        m_lane[tclip_pkg::LANE_CY]    = m_c;
        m_lane[tclip_pkg::LANE_HX]    = m_h;
        m_lane[tclip_pkg::LANE_HY]    = m_h;
        d_lane[tclip_pkg::LANE_CX]    = mx_reg;
        d_lane[tclip_pkg::LANE_CY]    = my_reg;
        d_lane[tclip_pkg::LANE_HX]    = mx_reg;
        d_lane[tclip_pkg::LANE_HY]    = my_reg;
        load_lane[tclip_pkg::LANE_CX] = '0;
        load_lane[tclip_pkg::LANE_CY] = m_c;
        load_lane[tclip_pkg::LANE_HX] = '0;
        load_lane[tclip_pkg::LANE_HY] = m_h;
        for (int i = 0; i < tclip_pkg::LANES; i++)
        begin
            w_lane[i]   = tclip_pkg::wrap_red(raw_reg[i], red_reg[i], d_lane[i], m_lane[i]);
            new_lane[i] = reload ? load_lane[i] : w_lane[i];
        end
        res_c = tclip_pkg::make_res(1'b0, reload,
                                    raw_reg[tclip_pkg::LANE_CX], raw_reg[tclip_pkg::LANE_CY],
                                    w_lane[tclip_pkg::LANE_CX], w_lane[tclip_pkg::LANE_CY],
                                    new_lane[tclip_pkg::LANE_CX], new_lane[tclip_pkg::LANE_CY],
                                    mx_reg, my_reg);
        res_h = tclip_pkg::make_res(1'b1, reload,
                                    raw_reg[tclip_pkg::LANE_HX], raw_reg[tclip_pkg::LANE_HY],
                                    w_lane[tclip_pkg::LANE_HX], w_lane[tclip_pkg::LANE_HY],
                                    new_lane[tclip_pkg::LANE_HX], new_lane[tclip_pkg::LANE_HY],
                                    mx_reg, my_reg);
    end

    always_comb
    begin
        first_pass_next = first_pass_reg;
        red_busy_next   = red_busy_reg;
        red_cnt_next    = red_cnt_reg;
        raw_next        = raw_reg;
        red_next        = red_reg;
        in_full_next    = in_full_reg;
        buf_full_next   = buf_full_reg;
        phase_next      = phase_reg;

        if (cfg_wr_en)
        begin
            red_busy_next = 1'b1;
            red_cnt_next  = CNT_W'(tclip_pkg::ORIGIN_W - 1);
            for (int i = 0; i < tclip_pkg::LANES; i++)
            begin
                red_next[i] = '0;
            end
        end
        else if (red_busy_reg)
        begin
            for (int i = 0; i < tclip_pkg::LANES; i++)
            begin
                red_next[i] = tclip_pkg::red_step(red_reg[i], raw_reg[i][red_cnt_reg], m_lane[i]);
            end
            if (red_cnt_reg == '0)
            begin
                red_busy_next = 1'b0;
            end
            else
            begin
                red_cnt_next = red_cnt_reg - CNT_W'(1);
            end
        end
        else if (move)
        begin
            first_pass_next = 1'b0;
            for (int i = 0; i < tclip_pkg::LANES; i++)
            begin
                raw_next[i] = new_lane[i];
                if (reload)
                begin
                    red_next[i] = '0;
                end
                else if (d_lane[i] != '0)
                begin
                    red_next[i] = w_lane[i];
                end
            end
        end

        if (move)
        begin
            buf_full_next = 1'b1;
            phase_next    = 1'b0;
        end
        else if (out_take)
        begin
            if (phase_reg)
            begin
                buf_full_next = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end

        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (move)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= tclip_pkg::GRID_RESET;
            first_pass_reg <= 1'b1;
            red_busy_reg   <= 1'b0;
            red_cnt_reg    <= '0;
            in_full_reg    <= 1'b0;
            buf_full_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            for (int i = 0; i < tclip_pkg::LANES; i++)
            begin
                raw_reg[i] <= '0;
                red_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                grid_size_reg <= cfg_wr_data;
            end
            first_pass_reg <= first_pass_next;
            red_busy_reg   <= red_busy_next;
            red_cnt_reg    <= red_cnt_next;
            in_full_reg    <= in_full_next;
            buf_full_reg   <= buf_full_next;
            phase_reg      <= phase_next;
            raw_reg        <= raw_next;
            red_reg        <= red_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mx_reg <= move_x;
            my_reg <= move_y;
        end
        if (move)
        begin
            res_buf_reg[0] <= res_c;
            res_buf_reg[1] <= res_h;
        end
    end

    assign res_out         = res_buf_reg[phase_reg];
    assign out_valid       = buf_full_reg;
    assign is_height_grid  = res_out.is_height_grid;
    assign last            = res_out.is_height_grid;
    assign full_reload     = res_out.full_reload;
    assign origin_x        = res_out.origin_x;
    assign origin_y        = res_out.origin_y;
    assign row_start_x     = res_out.row_start_x;
    assign row_start_y     = res_out.row_start_y;
    assign col_start_x     = res_out.col_start_x;
    assign col_start_y     = res_out.col_start_y;
    assign row_strip_valid = res_out.row_strip_valid;
    assign col_strip_valid = res_out.col_strip_valid;

`ifndef SYNTHESIS
    // No request may enter while the stored origins are being reduced.
    a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        red_busy_reg |-> !in_ready)
        else $error("request accepted during origin reduction");

    // The height result follows right after the colour result is taken.
    a_height_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (out_valid && last))
        else $error("height result missing after colour result");

    // At the end of a reduction pass every reduced origin is below its modulus.
    a_red_colour: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(red_busy_reg) |-> (red_reg[tclip_pkg::LANE_CX] < m_c)
                                && (red_reg[tclip_pkg::LANE_CY] < m_c))
        else $error("colour origin not reduced");

    a_red_height: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(red_busy_reg) |-> (red_reg[tclip_pkg::LANE_HX] < m_h)
                                && (red_reg[tclip_pkg::LANE_HY] < m_h))
        else $error("height origin not reduced");
`endif

endmodule

[test/tb_toroidal_clipmap_origin_update.sv]
// Testbench for toroidal_clipmap_origin_update: drives move requests under random
// idling and grid_size changes, and checks every grid result against a scoreboard.
// Depends on tclip_pkg and the RTL of the block only.
module tb_toroidal_clipmap_origin_update;

    typedef tclip_pkg::coord_t coord_t;
    typedef tclip_pkg::move_t  move_t;

    localparam coord_t GRID_RESET = tclip_pkg::GRID_RESET;
    localparam coord_t GRID_MIN   = tclip_pkg::GRID_MIN;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_AT_REQUEST = 300;
    localparam int HOLD_CYCLES     = 120;
    localparam int STEADY_FROM     = 600;
    localparam int STEADY_TO       = 800;
    localparam int PHASE_ITEMS     = 112;
    localparam int NUM_DIRECTED    = 23;
    localparam int NUM_PHASES      = 15;
    localparam int RANDOM_GRID     = -1;

    localparam int DIR_X [NUM_DIRECTED] = '{0, 0, 1, 0, -1, 0, 1, -1, 1, -1, 254, -254, 0, 0,
                                            254, -254, 255, 0, 2047, -2048, 2047, 100, -200};
    localparam int DIR_Y [NUM_DIRECTED] = '{0, 0, 0, 1, 0, -1, 1, -1, -1, 1, 0, 0, 254, -254,
                                            -254, 254, 0, -255, 2047, -2048, -2048, 37, 150};
    localparam int PHASE_GRID [NUM_PHASES] = '{3, 1023, 4, 0, 700, 1, 1023, 2, RANDOM_GRID,
                                               RANDOM_GRID, RANDOM_GRID, 512, RANDOM_GRID,
                                               1023, 3};

    typedef struct {
        logic   is_height_grid;
        logic   last;
        logic   full_reload;
        coord_t origin_x;
        coord_t origin_y;
        coord_t row_start_x;
        coord_t row_start_y;
        coord_t col_start_x;
        coord_t col_start_y;
        logic   row_strip_valid;
        logic   col_strip_valid;
    } grid_result_t;

    class clipmap_origin_tracker;
        grid_result_t pending_results[$];
        coord_t grid_size;
        bit first_pass;
        int colour_ox;
        int colour_oy;
        int height_ox;
        int height_oy;
        int mismatches;

        function new();
            grid_size  = GRID_RESET;
            first_pass = 1'b1;
            colour_ox  = 0;
            colour_oy  = 0;
            height_ox  = 0;
            height_oy  = 0;
            mismatches = 0;
        endfunction

        function void set_grid_size(coord_t value);
            grid_size = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        static function int wrap_coord(int o, int d, int m);
            int s;
            if (d == 0)
            begin
                return o;
            end
            s = o + d + ((d < 0) ? m : 0);
            if (s < 0)
            begin
                s = 0;
            end
            return s % m;
        endfunction

        static function grid_result_t strip_result(bit height, bit reload, int ox, int oy,
                                                   int dx, int dy, int m);
            grid_result_t r;
            bit rv;
            bit cv;
            rv = !reload && (dy != 0);
            cv = !reload && (dx != 0);
            r.is_height_grid  = height;
            r.last            = height;
            r.full_reload     = reload;
            r.origin_x        = '0;
            r.origin_y        = '0;
            r.row_start_x     = rv ? coord_t'(wrap_coord(ox, dx, m)) : '0;
            r.row_start_y     = rv ? coord_t'((dy > 0) ? wrap_coord(oy, dy, m) : oy) : '0;
            r.col_start_x     = cv ? coord_t'((dx > 0) ? ox : wrap_coord(ox, dx, m)) : '0;
            r.col_start_y     = cv ? coord_t'((dy < 0) ? wrap_coord(oy, dy, m) : oy) : '0;
            r.row_strip_valid = rv;
            r.col_strip_valid = cv;
            return r;
        endfunction

        function void note_move(move_t mx, move_t my);
            grid_result_t colour;
            grid_result_t height;
            int dx;
            int dy;
            int n;
            bit reload;
            dx = mx;
            dy = my;
            n = (grid_size < GRID_MIN) ? GRID_MIN : grid_size;
            reload = first_pass || (((dx < 0) ? -dx : dx) > n - 1)
                     || (((dy < 0) ? -dy : dy) > n - 1);
            if (reload)
            begin
                colour = strip_result(1'b0, 1'b1, 0, 0, dx, dy, n - 1);
                height = strip_result(1'b1, 1'b1, 0, 0, dx, dy, n);
                colour_ox  = 0;
                colour_oy  = n - 1;
                height_ox  = 0;
                height_oy  = n;
                first_pass = 1'b0;
            end
            else
            begin
                colour = strip_result(1'b0, 1'b0, colour_ox, colour_oy, dx, dy, n - 1);
                height = strip_result(1'b1, 1'b0, height_ox, height_oy, dx, dy, n);
                colour_ox = wrap_coord(colour_ox, dx, n - 1);
                colour_oy = wrap_coord(colour_oy, dy, n - 1);
                height_ox = wrap_coord(height_ox, dx, n);
                height_oy = wrap_coord(height_oy, dy, n);
            end
            colour.origin_x = coord_t'(colour_ox);
            colour.origin_y = coord_t'(colour_oy);
            height.origin_x = coord_t'(height_ox);
            height.origin_y = coord_t'(height_oy);
            pending_results.push_back(colour);
            pending_results.push_back(height);
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch %0d: %s", mismatches, what);
        endtask

        task check_field(string name, coord_t got, coord_t want);
            if (got !== want)
            begin
                report($sformatf("%s got %0d expected %0d", name, got, want));
            end
        endtask

        task check_grid_result(grid_result_t got);
            grid_result_t want;
            if (pending_results.size() == 0)
            begin
                report("grid result with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            check_field("is_height_grid", got.is_height_grid, want.is_height_grid);
            check_field("last", got.last, want.last);
            check_field("full_reload", got.full_reload, want.full_reload);
            check_field("origin_x", got.origin_x, want.origin_x);
            check_field("origin_y", got.origin_y, want.origin_y);
            check_field("row_start_x", got.row_start_x, want.row_start_x);
            check_field("row_start_y", got.row_start_y, want.row_start_y);
            check_field("col_start_x", got.col_start_x, want.col_start_x);
            check_field("col_start_y", got.col_start_y, want.col_start_y);
            check_field("row_strip_valid", got.row_strip_valid, want.row_strip_valid);
            check_field("col_strip_valid", got.col_strip_valid, want.col_strip_valid);
        endtask
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_wr_en = 1'b0;
    coord_t cfg_wr_data = '0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    move_t  move_x = '0;
    move_t  move_y = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   is_height_grid;
    logic   last;
    logic   full_reload;
    coord_t origin_x;
    coord_t origin_y;
    coord_t row_start_x;
    coord_t row_start_y;
    coord_t col_start_x;
    coord_t col_start_y;
    logic   row_strip_valid;
    logic   col_strip_valid;

    int items_sent = 0;
    int cycle_count = 0;
    logic steady;
    clipmap_origin_tracker tracker = new();

    assign steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);

    toroidal_clipmap_origin_update DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .move_x          (move_x),
        .move_y          (move_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_height_grid  (is_height_grid),
        .last            (last),
        .full_reload     (full_reload),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .row_start_x     (row_start_x),
        .row_start_y     (row_start_y),
        .col_start_x     (col_start_x),
        .col_start_y     (col_start_y),
        .row_strip_valid (row_strip_valid),
        .col_strip_valid (col_strip_valid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        grid_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.is_height_grid  = is_height_grid;
            got.last            = last;
            got.full_reload     = full_reload;
            got.origin_x        = origin_x;
            got.origin_y        = origin_y;
            got.row_start_x     = row_start_x;
            got.row_start_y     = row_start_y;
            got.col_start_x     = col_start_x;
            got.col_start_y     = col_start_y;
            got.row_strip_valid = row_strip_valid;
            got.col_strip_valid = col_strip_valid;
            tracker.check_grid_result(got);
        end
    end

    // Receiver stalls at random except in the steady window; one long hold fills the block.
    initial
    begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_used && items_sent >= HOLD_AT_REQUEST)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    function automatic move_t pick_move(int n);
        int r;
        int mag;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return move_t'($urandom_range(4095));
        end
        if (r < 18)
        begin
            return '0;
        end
        if (r < 26)
        begin
            mag = n - 1;
        end
        else if (r < 30)
        begin
            mag = n;
        end
        else if (r < 70)
        begin
            mag = $urandom_range(1, (n - 1 < 8) ? n - 1 : 8);
        end
        else
        begin
            mag = $urandom_range(1, n - 1);
        end
        return ($urandom_range(1) != 0) ? move_t'(-mag) : move_t'(mag);
    endfunction

    task automatic send_move(move_t mx, move_t my);
        while (!steady && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        move_x   <= mx;
        move_y   <= my;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tracker.note_move(mx, my);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_grid_size(coord_t value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_grid_size(value);
    endtask

    initial
    begin
        int grid;
        int eff;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_move(move_t'(DIR_X[i]), move_t'(DIR_Y[i]));
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            grid = (PHASE_GRID[p] == RANDOM_GRID) ? $urandom_range(3, 1023) : PHASE_GRID[p];
            write_grid_size(coord_t'(grid));
            eff = (grid < GRID_MIN) ? GRID_MIN : grid;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_move(pick_move(eff), pick_move(eff));
            end
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
sv/tclip_pkg.sv
sv/toroidal_clipmap_origin_update.sv
test/tb_toroidal_clipmap_origin_update.sv
